@@ rtl/fba_pkg.sv @@
`timescale 1ns / 1ps

package fba_pkg;

  // Payload widths
  localparam int REQ_W = 2;
  localparam int SB_W  = 10;
  localparam int LEN_W = 11;
  localparam int ST_W  = 2;
  localparam int BI_W  = 10;
  localparam int DAT_W = 16;

  // Stream widths (whole bytes)
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FORMAT = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_ERROR   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic            load;       // capture request fields
    logic            find_init;  // zero scan pointer and pipeline
    logic            find_step;  // scan one entry
    logic            ptr_start;  // pointer to start block, clear walk steps
    logic            alloc_wr;   // write one chain link
    logic            free_step;  // follow one chain link
    logic            ptr_clr;    // zero pointer for a clearing sweep
    logic            clr_wr;     // clear one entry
    logic            res_load;   // capture result
    logic [ST_W-1:0] res_code;
    logic            res_found;  // result carries the found index
    logic            out_load;   // move result to output register
  } fba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             find_big;
    logic             alloc_bad;
    logic             free_bad;
    logic             find_hit;
    logic             find_miss;
    logic             alloc_last;
    logic             free_ok;
    logic             free_err;
    logic             clr_last;
    logic             out_free;
  } fba_sts_t;

endpackage

@@ rtl/fat_block_allocator.sv @@
`timescale 1ns / 1ps

// Block allocation table of NUM_BLOCKS 16-bit next-block links (zero = free,
// END_MARK = end of chain) in a single table memory with one write and one
// registered read per cycle. One request in, one result out. After reset the
// table is cleared one entry per cycle through all NUM_BLOCKS entries with s_tready low.
// Per request: find scans one entry per cycle, the longest case being a scan
// that finds no room; allocate writes one link per cycle; free follows one
// link per cycle through the read port; format clears every entry; and a
// request rejected on range goes straight to the result. A new request is
// taken while the previous result waits in the output register.

module fat_block_allocator import fba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024,
  parameter int END_MARK   = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] start_block, [20:10] run_length
  input  logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] block_index
  output logic [ST_W-1:0]      m_tuser    // [1:0] status
);

  fba_cmd_t        cmd;
  fba_sts_t        sts;
  logic [BI_W-1:0] block_index;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .END_MARK   (END_MARK)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .req_type    (s_tuser),
    .start_block (s_tdata[SB_W-1:0]),
    .run_length  (s_tdata[SB_W+LEN_W-1:SB_W]),
    .cmd         (cmd),
    .sts         (sts),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .status      (m_tuser),
    .block_index (block_index)
  );

  // Output payload packing
  assign m_tdata = M_TDATA_W'(block_index);

endmodule

@@ rtl/fba_dpath.sv @@
`timescale 1ns / 1ps

module fba_dpath import fba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024,
  parameter int END_MARK   = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [REQ_W-1:0] req_type,
  input  logic [SB_W-1:0]  start_block,
  input  logic [LEN_W-1:0] run_length,
  input  fba_cmd_t         cmd,
  output fba_sts_t         sts,
  input  logic             m_tready,
  output logic             m_tvalid,
  output logic [ST_W-1:0]  status,
  output logic [BI_W-1:0]  block_index
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int SW = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam logic [CW-1:0]    NB_C   = CW'(NUM_BLOCKS);
  localparam logic [CW-1:0]    LAST_C = CW'(NUM_BLOCKS - 1);
  localparam logic [SW-1:0]    NB_S   = SW'(NUM_BLOCKS);
  localparam logic [DAT_W:0]   NB_D   = (DAT_W + 1)'(NUM_BLOCKS);
  localparam logic [DAT_W-1:0] END_D  = DAT_W'(END_MARK);

  // Link table
  logic [DAT_W-1:0] mem [NUM_BLOCKS];
  logic [DAT_W-1:0] rdata;

  // Request registers
  logic [REQ_W-1:0] req;
  logic [SB_W-1:0]  start_r;
  logic [LEN_W-1:0] len;

  // Walk state
  logic [CW-1:0]    ptr;
  logic [IW-1:0]    dptr;
  logic             rd_pend;
  logic [LEN_W-1:0] run;
  logic [CW-1:0]    steps;

  // Result holding
  logic [ST_W-1:0]  res_status;
  logic [BI_W-1:0]  res_index;

  logic [SW-1:0]    sum;
  logic [LEN_W-1:0] run_inc;
  logic [IW-1:0]    found_idx;
  logic [CW-1:0]    ptr_inc;
  logic             alloc_last;
  logic             steps_over;
  logic             nxt_end;
  logic             nxt_bad;
  logic             free_ok;
  logic             free_err;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [DAT_W-1:0] wdata;
  logic [IW-1:0]    raddr;

  // Range checks and walk conditions
  always_comb begin
    sum        = SW'(start_r) + SW'(len);
    run_inc    = run + 1'b1;
    found_idx  = dptr - IW'(len - 1'b1);
    ptr_inc    = ptr + 1'b1;
    alloc_last = (SW'(ptr) + 1'b1) == sum;
    steps_over = steps == NB_C;
    nxt_end    = rdata == END_D;
    nxt_bad    = (rdata == '0) || ({1'b0, rdata} >= NB_D);
    free_ok    = !steps_over && nxt_end;
    free_err   = steps_over || (!nxt_end && nxt_bad);
  end

  always_comb begin
    sts.req        = req;
    sts.find_big   = SW'(len) > NB_S;
    sts.alloc_bad  = sum > NB_S;
    sts.free_bad   = SW'(start_r) >= NB_S;
    sts.find_hit   = rd_pend && (rdata == '0) && (run_inc >= len);
    sts.find_miss  = !rd_pend && (ptr == NB_C);
    sts.alloc_last = alloc_last;
    sts.free_ok    = free_ok;
    sts.free_err   = free_err;
    sts.clr_last   = ptr == LAST_C;
    sts.out_free   = !m_tvalid || m_tready;
  end

  // Table port control
  always_comb begin
    we    = cmd.alloc_wr || cmd.clr_wr || (cmd.free_step && !steps_over);
    waddr = ptr[IW-1:0];
    wdata = '0;
    if (cmd.alloc_wr) begin
      wdata = alloc_last ? END_D : DAT_W'(SW'(ptr) + 1'b1);
    end
    raddr = cmd.free_step ? rdata[IW-1:0] : ptr[IW-1:0];
  end

  // Table: write-first on a same-address read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

  // Request capture, zero length counts as one
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= req_type;
      start_r <= start_block;
      len     <= (run_length == '0) ? LEN_W'(1) : run_length;
    end
  end

  // Pointer and scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.ptr_clr || cmd.find_init) begin
        ptr <= '0;
      end else if (cmd.ptr_start) begin
        ptr <= CW'(start_r);
      end else if (cmd.alloc_wr || cmd.clr_wr) begin
        ptr <= ptr_inc;
      end else if (cmd.find_step && (ptr != NB_C)) begin
        ptr <= ptr_inc;
      end else if (cmd.free_step && !free_ok && !free_err) begin
        ptr <= CW'(rdata);
      end
      if (cmd.find_init) begin
        rd_pend <= 1'b0;
      end else if (cmd.find_step) begin
        rd_pend <= ptr != NB_C;
      end
    end
  end

  // Run length, entry tag and walk step count
  always_ff @(posedge clk) begin
    if (cmd.find_init) begin
      run <= '0;
    end else if (cmd.find_step && rd_pend) begin
      run <= (rdata == '0) ? run_inc : '0;
    end
    if (cmd.find_step) begin
      dptr <= ptr[IW-1:0];
    end
    if (cmd.ptr_start) begin
      steps <= '0;
    end else if (cmd.free_step && !steps_over) begin
      steps <= steps + 1'b1;
    end
  end

  // Result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_index  <= cmd.res_found ? BI_W'(found_idx) : '0;
    end
    if (cmd.out_load) begin
      status      <= res_status;
      block_index <= res_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/fba_ctrl.sv @@
`timescale 1ns / 1ps

module fba_ctrl import fba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  fba_sts_t sts,
  output fba_cmd_t cmd
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_FIND    = 4'd3;
  localparam logic [3:0] S_ALLOC   = 4'd4;
  localparam logic [3:0] S_FREE_RD = 4'd5;
  localparam logic [3:0] S_FREE    = 4'd6;
  localparam logic [3:0] S_FMT     = 4'd7;
  localparam logic [3:0] S_RESULT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = state == S_IDLE;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req)
          REQ_FIND: begin
            if (sts.find_big) begin
              cmd.res_load = 1'b1;
              cmd.res_code = ST_ERROR;
              state_next   = S_RESULT;
            end else begin
              cmd.find_init = 1'b1;
              state_next    = S_FIND;
            end
          end
          REQ_ALLOC: begin
            if (sts.alloc_bad) begin
              cmd.res_load = 1'b1;
              cmd.res_code = ST_ERROR;
              state_next   = S_RESULT;
            end else begin
              cmd.ptr_start = 1'b1;
              state_next    = S_ALLOC;
            end
          end
          REQ_FREE: begin
            if (sts.free_bad) begin
              cmd.res_load = 1'b1;
              cmd.res_code = ST_ERROR;
              state_next   = S_RESULT;
            end else begin
              cmd.ptr_start = 1'b1;
              state_next    = S_FREE_RD;
            end
          end
          REQ_FORMAT: begin
            cmd.ptr_clr = 1'b1;
            state_next  = S_FMT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (sts.find_hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_code  = ST_OK;
          cmd.res_found = 1'b1;
          state_next    = S_RESULT;
        end else if (sts.find_miss) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOSPACE;
          state_next   = S_RESULT;
        end
      end
      S_ALLOC: begin
        cmd.alloc_wr = 1'b1;
        if (sts.alloc_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_RESULT;
        end
      end
      S_FREE_RD: begin
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.free_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_RESULT;
        end else if (sts.free_err) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_ERROR;
          state_next   = S_RESULT;
        end
      end
      S_FMT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/fba_checker.sv @@
`timescale 1ns / 1ps

module fba_checker import fba_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [ST_W-1:0]      m_tuser
);

  logic       s_xfer;
  logic       m_xfer;
  logic [1:0] pending;

  assign s_xfer = s_tvalid && s_tready;
  assign m_xfer = m_tvalid && m_tready;

  // Requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s_xfer && !m_xfer) begin
      pending <= pending + 1'b1;
    end else if (m_xfer && !s_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  // A result only answers a request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 2'd0)
    else $error("result without an outstanding request");

  // At most one request in work beside one waiting result
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    s_xfer |-> pending <= 2'd1)
    else $error("request accepted while another is in work");

  // Index is zero unless the result is a success
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> m_tdata == '0)
    else $error("nonzero index on a failed result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind fat_block_allocator fba_checker u_fba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
